[sv/mtep_pkg.sv]
// Package for the MIDI track event parser.
// Holds the phase encoding, the result record and the sizing constants.
// No dependencies.
package mtep_pkg;

    localparam int MAX_VLQ_BYTES = 4;
    localparam int VLQ_CNT_W     = 3;
    localparam int VLQ_ACC_W     = 28;
    localparam int TIME_W        = 32;

    localparam logic [VLQ_CNT_W-1:0] VLQ_LAST_CNT = VLQ_CNT_W'(MAX_VLQ_BYTES - 1);

    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [2:0] MT_SYSTEM     = 3'd7;
    localparam logic [2:0] MT_PROG_CHG   = 3'd4;
    localparam logic [2:0] MT_CHAN_PRESS = 3'd5;

    typedef enum logic [1:0] {
        KIND_CHANNEL    = 2'd0,
        KIND_META_BYTE  = 2'd1,
        KIND_META_EMPTY = 2'd2,
        KIND_ERROR      = 2'd3
    } t_kind;

    typedef enum logic [7:0] {
        PH_DELTA  = 8'b0000_0001,
        PH_STATUS = 8'b0000_0010,
        PH_DATA1  = 8'b0000_0100,
        PH_DATA2  = 8'b0000_1000,
        PH_LEN    = 8'b0001_0000,
        PH_SKIP   = 8'b0010_0000,
        PH_MTYPE  = 8'b0100_0000,
        PH_MDATA  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_kind              result_kind;
        logic [TIME_W-1:0]  event_time;
        logic [2:0]         message_type;
        logic [3:0]         channel;
        logic [7:0]         data_first;
        logic [7:0]         data_second;
        logic [7:0]         meta_code;
        logic [7:0]         meta_byte;
        logic               meta_last;
    } t_result;

endpackage

[sv/mtep_parser.sv]
// Parser state and per-byte decode for the MIDI track event parser.
// Updates the parse state on each accepted byte and forms at most one result.
// Depends on mtep_pkg.
module mtep_parser
    import mtep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_track_start,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase                  r_phase,     n_phase;
    logic [VLQ_ACC_W-1:0]    r_accum,     n_accum;
    logic [VLQ_CNT_W-1:0]    r_count,     n_count;
    logic [TIME_W-1:0]       r_abs_time,  n_abs_time;
    logic [7:0]              r_status,    n_status;
    logic                    r_status_ok, n_status_ok;
    logic [VLQ_ACC_W-1:0]    r_left,      n_left;
    logic [7:0]              r_held,      n_held;
    logic [7:0]              r_meta_code, n_meta_code;

    t_phase                  e_phase;
    logic [VLQ_ACC_W-1:0]    e_accum;
    logic [VLQ_CNT_W-1:0]    e_count;
    logic [TIME_W-1:0]       e_abs_time;
    logic [7:0]              e_status;
    logic                    e_status_ok;
    logic [VLQ_ACC_W-1:0]    e_left;
    logic [7:0]              e_held;
    logic [7:0]              e_meta_code;

    logic [VLQ_ACC_W-1:0]    acc_new;
    logic                    cont;
    logic                    overlong;
    logic                    one_byte;
    logic [VLQ_ACC_W-1:0]    left_dec;

    always_comb begin
        e_phase     = i_track_start ? PH_DELTA : r_phase;
        e_accum     = i_track_start ? '0 : r_accum;
        e_count     = i_track_start ? '0 : r_count;
        e_abs_time  = i_track_start ? '0 : r_abs_time;
        e_status    = i_track_start ? '0 : r_status;
        e_status_ok = i_track_start ? 1'b0 : r_status_ok;
        e_left      = i_track_start ? '0 : r_left;
        e_held      = i_track_start ? '0 : r_held;
        e_meta_code = i_track_start ? '0 : r_meta_code;
    end

    assign acc_new  = {e_accum[VLQ_ACC_W-8:0], i_data_byte[6:0]};
    assign cont     = i_data_byte[7];
    assign overlong = cont && (e_count == VLQ_LAST_CNT);
    assign one_byte = (e_status[6:4] == MT_PROG_CHG) || (e_status[6:4] == MT_CHAN_PRESS);
    assign left_dec = (e_left != '0) ? e_left - VLQ_ACC_W'(1) : '0;

    always_comb begin
        n_phase     = e_phase;
        n_accum     = e_accum;
        n_count     = e_count;
        n_abs_time  = e_abs_time;
        n_status    = e_status;
        n_status_ok = e_status_ok;
        n_left      = e_left;
        n_held      = e_held;
        n_meta_code = e_meta_code;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.event_time = e_abs_time;

        unique case (e_phase)
            PH_DELTA: begin
                if (!cont) begin
                    n_abs_time = e_abs_time + TIME_W'(acc_new);
                    n_accum    = '0;
                    n_count    = '0;
                    n_phase    = PH_STATUS;
                end else if (overlong) begin
                    o_res_valid       = 1'b1;
                    o_res.result_kind = KIND_ERROR;
                    n_accum           = '0;
                    n_count           = '0;
                    n_phase           = PH_DELTA;
                end else begin
                    n_accum = acc_new;
                    n_count = e_count + VLQ_CNT_W'(1);
                end
            end
            PH_STATUS: begin
                if (i_data_byte == ST_SYSEX || i_data_byte == ST_SYSEX_CONT) begin
                    n_held  = '0;
                    n_accum = '0;
                    n_count = '0;
                    n_phase = PH_LEN;
                end else if (i_data_byte == ST_META) begin
                    n_phase = PH_MTYPE;
                end else if (i_data_byte[7]) begin
                    if (i_data_byte[6:4] == MT_SYSTEM) begin
                        n_status_ok       = 1'b0;
                        n_status          = '0;
                        o_res_valid       = 1'b1;
                        o_res.result_kind = KIND_ERROR;
                        n_accum           = '0;
                        n_count           = '0;
                        n_phase           = PH_DELTA;
                    end else begin
                        n_status    = i_data_byte;
                        n_status_ok = 1'b1;
                        n_phase     = PH_DATA1;
                    end
                end else if (!e_status_ok) begin
                    o_res_valid       = 1'b1;
                    o_res.result_kind = KIND_ERROR;
                    n_accum           = '0;
                    n_count           = '0;
                    n_phase           = PH_DELTA;
                end else if (one_byte) begin
                    o_res_valid        = 1'b1;
                    o_res.result_kind  = KIND_CHANNEL;
                    o_res.message_type = e_status[6:4];
                    o_res.channel      = e_status[3:0];
                    o_res.data_first   = i_data_byte;
                    n_phase            = PH_DELTA;
                end else begin
                    n_held  = i_data_byte;
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA1: begin
                if (one_byte) begin
                    o_res_valid        = 1'b1;
                    o_res.result_kind  = KIND_CHANNEL;
                    o_res.message_type = e_status[6:4];
                    o_res.channel      = e_status[3:0];
                    o_res.data_first   = i_data_byte;
                    n_phase            = PH_DELTA;
                end else begin
                    n_held  = i_data_byte;
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA2: begin
                o_res_valid        = 1'b1;
                o_res.result_kind  = KIND_CHANNEL;
                o_res.message_type = e_status[6:4];
                o_res.channel      = e_status[3:0];
                o_res.data_first   = e_held;
                o_res.data_second  = i_data_byte;
                n_phase            = PH_DELTA;
            end
            PH_MTYPE: begin
                n_meta_code = i_data_byte;
                n_held      = 8'd1;
                n_accum     = '0;
                n_count     = '0;
                n_phase     = PH_LEN;
            end
            PH_LEN: begin
                if (!cont) begin
                    n_left  = acc_new;
                    n_accum = '0;
                    n_count = '0;
                    if (e_held != '0) begin
                        if (acc_new == '0) begin
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_META_EMPTY;
                            o_res.meta_code   = e_meta_code;
                            n_phase           = PH_DELTA;
                        end else begin
                            n_phase = PH_MDATA;
                        end
                    end else begin
                        n_phase = (acc_new == '0) ? PH_DELTA : PH_SKIP;
                    end
                end else if (overlong) begin
                    o_res_valid       = 1'b1;
                    o_res.result_kind = KIND_ERROR;
                    n_accum           = '0;
                    n_count           = '0;
                    n_phase           = PH_DELTA;
                end else begin
                    n_accum = acc_new;
                    n_count = e_count + VLQ_CNT_W'(1);
                end
            end
            PH_SKIP: begin
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_DELTA;
                end
            end
            PH_MDATA: begin
                o_res_valid       = 1'b1;
                o_res.result_kind = KIND_META_BYTE;
                o_res.meta_code   = e_meta_code;
                o_res.meta_byte   = i_data_byte;
                o_res.meta_last   = (e_left <= VLQ_ACC_W'(1));
                n_left            = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_DELTA;
                end
            end
            default: begin
                n_phase = PH_DELTA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELTA;
            r_accum     <= '0;
            r_count     <= '0;
            r_abs_time  <= '0;
            r_status    <= '0;
            r_status_ok <= 1'b0;
            r_left      <= '0;
            r_held      <= '0;
            r_meta_code <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_accum     <= n_accum;
            r_count     <= n_count;
            r_abs_time  <= n_abs_time;
            r_status    <= n_status;
            r_status_ok <= n_status_ok;
            r_left      <= n_left;
            r_held      <= n_held;
            r_meta_code <= n_meta_code;
        end
    end

endmodule

[sv/mtep_out_stage.sv]
// Result register with skid entry for the MIDI track event parser.
// Decouples input acceptance from output backpressure.
// Depends on mtep_pkg.
module mtep_out_stage
    import mtep_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_res_valid,
    input  t_result  i_res,
    output logic     o_in_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free   = i_ready || !r_out_valid;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // advance the skid item first; park a new item when the output stalls
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

[sv/midi_track_event_parser.sv]
// Top level of the MIDI track event parser: byte stream in, event items out.
// Instantiates mtep_parser and mtep_out_stage; depends on mtep_pkg.
//
// One track byte is taken per cycle while s_axis_tready is high, and each byte
// yields zero or one event item. The parse state is updated in the cycle a byte
// is taken; a result register plus one skid entry hold items, so input ready
// drops only when both are full under output stall.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] track_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] event_time, [34:32] message_type, [38:35] channel,
    // [46:39] data_first, [54:47] data_second, [62:55] meta_code,
    // [70:63] meta_byte, [71] zero
    output logic [71:0]  m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] result_kind
    output logic         m_axis_tlast    // meta_last
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    mtep_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (s_axis_tdata),
        .i_track_start (s_axis_tuser[0]),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    mtep_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (accept && res_valid),
        .i_res       (res),
        .o_in_ready  (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.meta_byte, out_res.meta_code,
                           out_res.data_second, out_res.data_first,
                           out_res.channel, out_res.message_type,
                           out_res.event_time};
    assign m_axis_tuser = out_res.result_kind;
    assign m_axis_tlast = out_res.meta_last;

endmodule
